FILE: src/lte_cell_ref_signal_generator_defines.svh
// ----------------------------------------------------------------------------
// LTE cell reference signal generator - assertion macros
// Shared assertion wrappers. Simulation builds get the checks and synthesis
// builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef LTE_CELL_REF_SIGNAL_GENERATOR_DEFINES_SVH
`define LTE_CELL_REF_SIGNAL_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check that the antecedent implies the consequent in the same cycle
`define LCRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcrs assertion failed");

// Check that the antecedent implies the consequent in the next cycle
`define LCRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcrs assertion failed");

`else

`define LCRS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define LCRS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: src/lcrs_pkg.sv
// ----------------------------------------------------------------------------
// LTE cell reference signal generator - package
// Types, constants and small helper functions shared by the generator.
// ----------------------------------------------------------------------------
package lcrs_pkg;

    // Largest downlink bandwidth in resource blocks
    localparam int unsigned MAX_RB     = 110;
    localparam int unsigned MIN_RB     = 6;
    // Gold sequence offset, counted in pairs of steps
    localparam int unsigned GOLD_PAIRS = 800;

    localparam logic signed [15:0] QPSK_POS = 16'sd23170;
    localparam logic signed [15:0] QPSK_NEG = -16'sd23170;

    // Configuration register indexes
    localparam logic [1:0] CFG_CELL_ID     = 2'd0;
    localparam logic [1:0] CFG_EXTENDED_CP = 2'd1;
    localparam logic [1:0] CFG_ANT_PORT    = 2'd2;
    localparam logic [1:0] CFG_PRB_COUNT   = 2'd3;

    // Antenna ports
    localparam logic [1:0] ANT_PORT0 = 2'd0;
    localparam logic [1:0] ANT_PORT1 = 2'd1;
    localparam logic [1:0] ANT_PORT2 = 2'd2;
    localparam logic [1:0] ANT_PORT3 = 2'd3;

    typedef struct packed {
        logic [4:0] slot;
        logic       ref_symbol;
        logic       restart;
    } lcrs_in_t;

    typedef struct packed {
        logic signed [15:0] re_value;
        logic signed [15:0] im_value;
        logic [10:0]        subcarrier;
        logic [2:0]         symbol_in_slot;
        logic               last;
    } lcrs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_LOAD,
        ST_SKIP,
        ST_EMIT
    } lcrs_state_t;

    // Control of the shared Gold unit
    typedef struct packed {
        logic load;
        logic advance;
    } lcrs_gold_ctrl_t;

    // Clamp the bandwidth into the supported range
    function automatic logic [6:0] eff_prb(input logic [6:0] prb);
        logic [6:0] p;
        p = prb;
        if (p < 7'(MIN_RB)) p = 7'(MIN_RB);
        if (p > 7'(MAX_RB)) p = 7'(MAX_RB);
        return p;
    endfunction

    // Remainder by six through a reciprocal multiply, exact below 512
    function automatic logic [2:0] mod6(input logic [8:0] x);
        logic [18:0] prod;
        logic [6:0]  q;
        logic [9:0]  r;
        prod = {10'd0, x} * 19'd683;
        q    = prod[18:12];
        r    = {1'b0, x} - ({1'b0, q, 2'b00} + {2'b00, q, 1'b0});
        return r[2:0];
    endfunction

endpackage

FILE: src/lcrs_gold_unit.sv
// ----------------------------------------------------------------------------
// LTE cell reference signal generator - Gold sequence unit
// Holds the two length-31 shift registers and advances both by two steps a
// cycle while advance is set. Serves both the fast-forward and element output.
// ----------------------------------------------------------------------------
module lcrs_gold_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lcrs_pkg::lcrs_gold_ctrl_t ctrl,
    input  logic [30:0]               seed,
    output logic [1:0]                bits
);
    import lcrs_pkg::*;

    logic [30:0] x1_reg, x1_next;
    logic [30:0] x2_reg, x2_next;
    logic [30:0] x1_mid, x2_mid;

    // Two chained steps of both registers
    always_comb begin
        x1_mid  = {x1_reg[0] ^ x1_reg[3], x1_reg[30:1]};
        x2_mid  = {x2_reg[0] ^ x2_reg[1] ^ x2_reg[2] ^ x2_reg[3], x2_reg[30:1]};
        bits[0] = x1_reg[0] ^ x2_reg[0];
        bits[1] = x1_mid[0] ^ x2_mid[0];
        if (ctrl.load) begin
            x1_next = 31'd1;
            x2_next = seed;
        end else if (ctrl.advance) begin
            x1_next = {x1_mid[0] ^ x1_mid[3], x1_mid[30:1]};
            x2_next = {x2_mid[0] ^ x2_mid[1] ^ x2_mid[2] ^ x2_mid[3], x2_mid[30:1]};
        end else begin
            x1_next = x1_reg;
            x2_next = x2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
        end else begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

endmodule

FILE: src/lcrs_seed_calc.sv
// ----------------------------------------------------------------------------
// LTE cell reference signal generator - seed calculation
// Forms c_init from slot, symbol and cell identity with one registered
// multiply.
// ----------------------------------------------------------------------------
module lcrs_seed_calc (
    input  logic        aclk,
    input  logic        capture,
    input  logic [4:0]  slot,
    input  logic [2:0]  symbol,
    input  logic [8:0]  cell_id,
    input  logic        extended_cp,
    output logic [30:0] cinit
);
    import lcrs_pkg::*;

    logic [7:0]  slot_term;
    logic [17:0] prod_reg, prod_next;

    // 7*(slot+1) + l + 1 written as 8*slot - slot + 8 + l
    always_comb begin
        slot_term = {slot, 3'b000} - {3'b000, slot} + 8'd8 + {5'd0, symbol};
        prod_next = capture ? ({10'd0, slot_term} * {8'd0, cell_id, 1'b1}) : prod_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // Scale by 1024 and add 2*cell_id + N_cp
    assign cinit = {3'b000, prod_reg, 10'd0} + {21'd0, cell_id, ~extended_cp};

endmodule

FILE: src/lte_cell_ref_signal_generator.sv
// ----------------------------------------------------------------------------
// LTE cell reference signal generator - top level
// Cell-specific reference symbols for one antenna port, one QPSK element per
// request, with subcarrier and symbol index.
//
//   Channel  Ports            Direction  Contents
//   input    s_valid/s_ready  in         slot, ref_symbol, restart
//   result   m_valid/m_ready  out        re, im, subcarrier, symbol, last
//   config   cfg_we           in         cell_id, extended_cp, port, prbs
//
// A continuing request emits its element straight into the result register;
// the Gold unit steps twice per cycle while it advances. A restart request
// seeds, loads and fast-forwards the shared Gold unit before its element.
// Reset clears configuration (prb count to minimum), sequence registers, row counters.
// A stalled result holds the input side off until it is taken.
// ----------------------------------------------------------------------------
`include "lte_cell_ref_signal_generator_defines.svh"

module lte_cell_ref_signal_generator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcrs_pkg::lcrs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lcrs_pkg::lcrs_out_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data
);
    import lcrs_pkg::*;

    lcrs_state_t     state_reg, state_next;
    logic [8:0]      cell_id_reg;
    logic            ext_cp_reg;
    logic [1:0]      port_reg;
    logic [6:0]      prb_reg;
    logic [4:0]      slot_reg, slot_next;
    logic [2:0]      row_symbol_reg, row_symbol_next;
    logic [2:0]      row_shift_reg, row_shift_next;
    logic [7:0]      elem_reg, elem_next;
    logic [9:0]      skip_reg, skip_next;
    logic            m_valid_reg, m_valid_next;
    lcrs_out_t       m_data_reg, m_data_next;
    lcrs_gold_ctrl_t gold_ctrl;
    logic [1:0]      gold_bits;
    logic [30:0]     cinit;
    logic            out_free;
    logic            s_accept;
    logic            emit;
    logic [6:0]      prb_eff;
    logic [7:0]      last_idx;
    logic [2:0]      sym_l;
    logic [2:0]      shift_v;
    logic [3:0]      shift_sum;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_id_reg <= '0;
            ext_cp_reg  <= 1'b0;
            port_reg    <= ANT_PORT0;
            prb_reg     <= 7'(MIN_RB);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CELL_ID:     cell_id_reg <= cfg_data;
                CFG_EXTENDED_CP: ext_cp_reg  <= cfg_data[0];
                CFG_ANT_PORT:    port_reg    <= cfg_data[1:0];
                CFG_PRB_COUNT:   prb_reg     <= cfg_data[6:0];
                default:         cell_id_reg <= cell_id_reg;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_valid && s_ready;
    assign prb_eff  = eff_prb(prb_reg);
    assign last_idx = {prb_eff, 1'b0} - 8'd1;

    // Symbol index and frequency shift of a new row
    always_comb begin
        if (port_reg == ANT_PORT0 || port_reg == ANT_PORT1) begin
            sym_l = s_data.ref_symbol ? (ext_cp_reg ? 3'd3 : 3'd4) : 3'd0;
        end else begin
            sym_l = 3'd1;
        end
        case (port_reg)
            ANT_PORT0: shift_v = (sym_l == 3'd0) ? 3'd0 : 3'd3;
            ANT_PORT1: shift_v = (sym_l == 3'd0) ? 3'd3 : 3'd0;
            ANT_PORT2: shift_v = s_data.slot[0] ? 3'd3 : 3'd0;
            ANT_PORT3: shift_v = s_data.slot[0] ? 3'd6 : 3'd3;
            default:   shift_v = 3'd0;
        endcase
        shift_sum = {1'b0, shift_v} + {1'b0, mod6(cell_id_reg)};
        if (shift_sum >= 4'd6) shift_sum = shift_sum - 4'd6;
    end

    // Sequencer: emit at once, or seed, load, fast-forward, then emit first element
    always_comb begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        row_symbol_next = row_symbol_reg;
        row_shift_next  = row_shift_reg;
        skip_next       = skip_reg;
        gold_ctrl       = '0;
        emit            = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_data.restart) begin
                        slot_next       = s_data.slot;
                        row_symbol_next = sym_l;
                        row_shift_next  = shift_sum[2:0];
                        state_next      = ST_SEED;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            ST_SEED: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                gold_ctrl.load = 1'b1;
                skip_next      = 10'(GOLD_PAIRS + MAX_RB) - {3'd0, prb_eff};
                state_next     = ST_SKIP;
            end
            ST_SKIP: begin
                gold_ctrl.advance = 1'b1;
                skip_next         = skip_reg - 10'd1;
                if (skip_reg == 10'd1) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit) gold_ctrl.advance = 1'b1;
    end

    // Element counter: clear on restart, advance on every element
    always_comb begin
        elem_next = elem_reg;
        if (s_accept && s_data.restart) elem_next = '0;
        else if (emit) elem_next = elem_reg + 8'd1;
    end

    // Build the result and hold it until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (emit) begin
            m_valid_next               = 1'b1;
            m_data_next.re_value       = gold_bits[0] ? QPSK_NEG : QPSK_POS;
            m_data_next.im_value       = gold_bits[1] ? QPSK_NEG : QPSK_POS;
            m_data_next.subcarrier     = {1'b0, elem_reg, 2'b00} + {2'b00, elem_reg, 1'b0}
                                         + {8'd0, row_shift_reg};
            m_data_next.symbol_in_slot = row_symbol_reg;
            m_data_next.last           = (elem_reg == last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            row_symbol_reg <= '0;
            row_shift_reg  <= '0;
            elem_reg       <= '0;
            skip_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            row_symbol_reg <= row_symbol_next;
            row_shift_reg  <= row_shift_next;
            elem_reg       <= elem_next;
            skip_reg       <= skip_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    lcrs_seed_calc u_seed (
        .aclk        (aclk),
        .capture     (state_reg == ST_SEED),
        .slot        (slot_reg),
        .symbol      (row_symbol_reg),
        .cell_id     (cell_id_reg),
        .extended_cp (ext_cp_reg),
        .cinit       (cinit)
    );

    lcrs_gold_unit u_gold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (gold_ctrl),
        .seed    (cinit),
        .bits    (gold_bits)
    );

    // Checks on the sequencer and the result handshake
    `LCRS_ASSERT_NEXT(a_restart_seeds, aclk, aresetn, s_accept && s_data.restart, state_reg == ST_SEED)
    `LCRS_ASSERT_SAME(a_skip_nonzero, aclk, aresetn, state_reg == ST_SKIP, skip_reg != 10'd0)
    `LCRS_ASSERT_NEXT(a_skip_ends, aclk, aresetn, state_reg == ST_SKIP && skip_reg == 10'd1, state_reg == ST_EMIT)
    `LCRS_ASSERT_SAME(a_result_taken, aclk, aresetn, $fell(m_valid_reg), $past(m_ready))

endmodule

FILE: verif/lcrs_refsig_checker.sv
// ----------------------------------------------------------------------------
// LTE cell reference signal generator - result checker
// Watches the request, result and register ports of the generator, keeps its
// own copy of the Gold sequence state and the register values, and checks
// every result against the element expected for the matching request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcrs_refsig_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  lcrs_pkg::lcrs_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lcrs_pkg::lcrs_out_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    output int                  mismatches,
    output int                  outstanding,
    output int                  rows_started,
    output int                  elements_checked,
    output int                  row_ends
);
    import lcrs_pkg::*;

    // Register copies
    logic [8:0]  cfg_cell_id;
    logic        cfg_ext_cp;
    logic [1:0]  cfg_port;
    logic [6:0]  cfg_rbs;

    // Sequence generator and row state
    logic [30:0] gold_x1;
    logic [30:0] gold_x2;
    logic [7:0]  re_index;
    logic [2:0]  re_shift;
    logic [2:0]  re_symbol;

    lcrs_out_t   expected_elements[$];

    // Advance both m-sequences by one step
    function automatic void gold_step();
        gold_x1 = {gold_x1[0] ^ gold_x1[3], gold_x1[30:1]};
        gold_x2 = {gold_x2[0] ^ gold_x2[1] ^ gold_x2[2] ^ gold_x2[3], gold_x2[30:1]};
    endfunction

    // Work out the element that one request produces and update the row state
    function automatic lcrs_out_t next_element(input lcrs_in_t req);
        lcrs_out_t   el;
        int unsigned rbs;
        int unsigned sym;
        int unsigned shift_v;
        int unsigned cid;
        int unsigned slot_n;
        int unsigned c_init;
        logic        b0;
        logic        b1;

        // Clamp the bandwidth into the supported range
        rbs = cfg_rbs;
        if (rbs < MIN_RB)
            rbs = MIN_RB;
        else if (rbs > MAX_RB)
            rbs = MAX_RB;

        if (req.restart) begin
            if (cfg_port == ANT_PORT0 || cfg_port == ANT_PORT1)
                sym = req.ref_symbol ? (cfg_ext_cp ? 3 : 4) : 0;
            else
                sym = 1;
            case (cfg_port)
                ANT_PORT0: shift_v = (sym == 0) ? 0 : 3;
                ANT_PORT1: shift_v = (sym == 0) ? 3 : 0;
                ANT_PORT2: shift_v = 3 * int'(req.slot[0]);
                default:   shift_v = 3 + 3 * int'(req.slot[0]);
            endcase
            cid       = cfg_cell_id;
            slot_n    = req.slot;
            re_symbol = 3'(sym);
            re_shift  = 3'((shift_v + cid % 6) % 6);
            c_init    = 1024 * (7 * (slot_n + 1) + sym + 1) * (2 * cid + 1)
                      + 2 * cid + (cfg_ext_cp ? 0 : 1);
            // Seed, then fast-forward past the Gold offset and the unused RBs
            gold_x1 = 31'd1;
            gold_x2 = c_init[30:0];
            repeat (2 * GOLD_PAIRS + 2 * (MAX_RB - rbs)) gold_step();
            re_index = 8'd0;
        end

        b0 = gold_x1[0] ^ gold_x2[0];
        gold_step();
        b1 = gold_x1[0] ^ gold_x2[0];
        gold_step();

        el.re_value       = b0 ? QPSK_NEG : QPSK_POS;
        el.im_value       = b1 ? QPSK_NEG : QPSK_POS;
        el.subcarrier     = 11'(6 * int'(re_index) + int'(re_shift));
        el.symbol_in_slot = re_symbol;
        el.last           = (int'(re_index) == 2 * rbs - 1);
        re_index          = re_index + 8'd1;
        return el;
    endfunction

    always @(posedge aclk) begin
        lcrs_out_t want;

        if (!aresetn) begin
            cfg_cell_id      = 9'd0;
            cfg_ext_cp       = 1'b0;
            cfg_port         = ANT_PORT0;
            cfg_rbs          = 7'(MIN_RB);
            gold_x1          = '0;
            gold_x2          = '0;
            re_index         = '0;
            re_shift         = '0;
            re_symbol        = '0;
            expected_elements.delete();
            mismatches       = 0;
            rows_started     = 0;
            elements_checked = 0;
            row_ends         = 0;
        end else begin
            // Track register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CELL_ID:     cfg_cell_id = cfg_data;
                    CFG_EXTENDED_CP: cfg_ext_cp  = cfg_data[0];
                    CFG_ANT_PORT:    cfg_port    = cfg_data[1:0];
                    CFG_PRB_COUNT:   cfg_rbs     = cfg_data[6:0];
                    default: ;
                endcase
            end

            // Predict the element for each accepted request
            if (s_valid && s_ready) begin
                if (s_data.restart)
                    rows_started++;
                expected_elements.push_back(next_element(s_data));
            end

            // Compare each delivered element with the oldest prediction
            if (m_valid && m_ready) begin
                elements_checked++;
                if (m_data.last)
                    row_ends++;
                if (expected_elements.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected element re %0d im %0d sc %0d sym %0d last %0b",
                                 $time, m_data.re_value, m_data.im_value, m_data.subcarrier,
                                 m_data.symbol_in_slot, m_data.last);
                    mismatches++;
                end else begin
                    want = expected_elements.pop_front();
                    if (m_data.re_value !== want.re_value
                            || m_data.im_value !== want.im_value
                            || m_data.subcarrier !== want.subcarrier
                            || m_data.symbol_in_slot !== want.symbol_in_slot
                            || m_data.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("%0t: element %0d expected re %0d im %0d sc %0d sym %0d last %0b",
                                     $time, elements_checked, want.re_value, want.im_value,
                                     want.subcarrier, want.symbol_in_slot, want.last);
                            $display("%0t: element %0d actual   re %0d im %0d sc %0d sym %0d last %0b",
                                     $time, elements_checked, m_data.re_value, m_data.im_value,
                                     m_data.subcarrier, m_data.symbol_in_slot, m_data.last);
                        end
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_elements.size();
    end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// LTE cell reference signal generator - testbench top
// Drives register settings and element requests into the generator: a short
// directed sequence for the corner cases, then random rows under random
// bandwidth, cell and port settings, with random idling on both channels.
// The checker beside the block predicts and compares every element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lcrs_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 1000;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    lcrs_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    lcrs_out_t m_data;
    logic      cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_CELL_ID;
    logic [8:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int rows_started;
    int elements_checked;
    int row_ends;

    bit idle_on       = 1'b1;
    int stall_left    = 0;
    int requests_sent = 0;
    int settings_used = 0;

    always #5 aclk = ~aclk;

    lte_cell_ref_signal_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcrs_refsig_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .rows_started     (rows_started),
        .elements_checked (elements_checked),
        .row_ends         (row_ends)
    );

    // Stall the result side in random bursts while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Present one request and hold it until accepted; valid stays up afterwards
    task automatic send_request(input logic [4:0] slot, input logic ref_sym,
                                input logic restart);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {slot, ref_sym, restart};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    // Drain the block, then write all four registers back to back
    task automatic write_regs(input logic [8:0] cid, input logic [8:0] ecp,
                              input logic [8:0] port, input logic [8:0] rbs);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CELL_ID;
        cfg_data  <= cid;
        @(negedge aclk);
        cfg_index <= CFG_EXTENDED_CP;
        cfg_data  <= ecp;
        @(negedge aclk);
        cfg_index <= CFG_ANT_PORT;
        cfg_data  <= port;
        @(negedge aclk);
        cfg_index <= CFG_PRB_COUNT;
        cfg_data  <= rbs;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    initial begin
        int         target;
        int         rbs;
        int         eff_rbs;
        int         len;
        int         kind;
        int         rows;
        logic [8:0] cid;
        logic [4:0] slot;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Elements before any restart come from an all-zero generator
        send_request(5'd31, 1'b1, 1'b0);
        send_request(5'd0, 1'b0, 1'b0);

        // Full row at the smallest bandwidth, running past its end
        write_regs(9'd503, 9'd0, 9'(ANT_PORT0), 9'd6);
        send_request(5'd0, 1'b0, 1'b1);
        repeat (13) send_request(5'($urandom), 1'($urandom), 1'b0);

        // Extended CP, cell id past the legal range, bandwidth clamped down
        write_regs(9'd511, 9'd1, 9'(ANT_PORT1), 9'd127);
        send_request(5'd19, 1'b1, 1'b1);
        send_request(5'd3, 1'b0, 1'b0);

        // Slot past the frame, bandwidth clamped up
        write_regs(9'd0, 9'd0, 9'(ANT_PORT2), 9'd0);
        send_request(5'd31, 1'b1, 1'b1);

        write_regs(9'd504, 9'd0, 9'(ANT_PORT3), 9'd5);
        send_request(5'd20, 1'b0, 1'b1);
        send_request(5'd20, 1'b0, 1'b0);

        write_regs(9'd5, 9'd1, 9'(ANT_PORT0), 9'd110);
        send_request(5'd7, 1'b1, 1'b1);

        // Change registers mid-row; the row keeps its shift and symbol
        write_regs(9'd250, 9'd0, 9'(ANT_PORT2), 9'd111);
        send_request(5'd7, 1'b1, 1'b0);

        // Random rows under random settings; no idling in the final stretch
        target = requests_sent + RANDOM_ITEMS;
        while (requests_sent < target) begin
            idle_on = (requests_sent < target - RANDOM_ITEMS / 6);
            case ($urandom_range(0, 3))
                0:       cid = 9'd0;
                1:       cid = 9'd503;
                2:       cid = 9'($urandom_range(504, 511));
                default: cid = 9'($urandom_range(0, 503));
            endcase
            case ($urandom_range(0, 7))
                0:       rbs = 6;
                1:       rbs = 110;
                2:       rbs = $urandom_range(0, 127);
                3:       rbs = $urandom_range(6, 110);
                default: rbs = $urandom_range(6, 16);
            endcase
            write_regs(cid, 9'($urandom), 9'($urandom), {2'($urandom), 7'(rbs)});
            eff_rbs = (rbs < 6) ? 6 : ((rbs > 110) ? 110 : rbs);

            rows = $urandom_range(1, 4);
            repeat (rows) begin
                // Mostly open a fresh row; now and then carry on the open one
                if (requests_sent < target && $urandom_range(0, 9) != 0) begin
                    slot = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(20, 31))
                                                       : 5'($urandom_range(0, 19));
                    send_request(slot, 1'($urandom), 1'b1);
                end
                kind = $urandom_range(0, 19);
                if (kind == 0)
                    len = 260;
                else if (kind < 5)
                    len = $urandom_range(0, 2 * eff_rbs + 4);
                else
                    len = 2 * eff_rbs - 1;
                // Stop once the request budget is spent
                repeat (len)
                    if (requests_sent < target)
                        send_request(5'($urandom), 1'($urandom), 1'b0);
            end
        end

        // Drop valid, wait for the last elements, then watch for strays
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Checked %0d elements in %0d restarted rows (%0d row ends)",
                 elements_checked, rows_started, row_ends);
        $display("under %0d register settings, %0d mismatches", settings_used, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Give up well past the slowest legal run
    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/lcrs_pkg.sv
src/lcrs_gold_unit.sv
src/lcrs_seed_calc.sv
src/lte_cell_ref_signal_generator.sv
verif/lcrs_refsig_checker.sv
verif/tb.sv
